@@ rtl/lota_pkg.sv @@
`default_nettype none
package lota_pkg;

  localparam logic [2:0] ACT_TICK     = 3'd0;
  localparam logic [2:0] ACT_EPOCH    = 3'd1;
  localparam logic [2:0] ACT_CLAIM    = 3'd2;
  localparam logic [2:0] ACT_RELEASE  = 3'd3;
  localparam logic [2:0] ACT_TERMINAL = 3'd4;
  localparam logic [2:0] ACT_STAMP    = 3'd5;
  localparam logic [2:0] ACT_QUERY    = 3'd6;

  localparam logic [1:0] KIND_NONE     = 2'd0;
  localparam logic [1:0] KIND_BLE      = 2'd1;
  localparam logic [1:0] KIND_LAN      = 2'd2;
  localparam logic [1:0] KIND_TERMINAL = 2'd3;

  typedef struct packed {
    logic [2:0]  action;
    logic [1:0]  who;
    logic [15:0] epoch;
  } in_item_t;

  typedef struct packed {
    logic        ok;
    logic [15:0] given_epoch;
    logic [1:0]  prev_who;
    logic [15:0] prev_epoch;
    logic [1:0]  owner_who;
    logic [15:0] owner_epoch;
    logic        is_owner;
    logic [31:0] idle_ms;
  } out_item_t;

  function automatic logic is_transport(input logic [1:0] k);
    return (k == KIND_BLE) || (k == KIND_LAN);
  endfunction

endpackage
`default_nettype wire

@@ rtl/lota_core.sv @@
`default_nettype none
module lota_core (
  input  wire logic               clk,
  input  wire logic               rst_n,
  input  wire logic               step,
  input  wire lota_pkg::in_item_t item,
  output lota_pkg::out_item_t     result
);

  logic [1:0]  owner_kind_r,  owner_kind_nxt;
  logic [15:0] owner_sess_r,  owner_sess_nxt;
  logic [15:0] epoch_src_r,   epoch_src_nxt;
  logic [31:0] now_r,         now_nxt;
  logic [31:0] base_r,        base_nxt;
  logic [15:0] epoch_inc;

  assign epoch_inc = epoch_src_r + 16'd1;

  always_comb begin
    owner_kind_nxt = owner_kind_r;
    owner_sess_nxt = owner_sess_r;
    epoch_src_nxt  = epoch_src_r;
    now_nxt        = now_r;
    base_nxt       = base_r;
    result         = '0;
    case (item.action)
      lota_pkg::ACT_TICK: begin
        now_nxt = now_r + 32'd1;
      end
      lota_pkg::ACT_EPOCH: begin
        // zero is never handed out
        epoch_src_nxt      = (epoch_inc == 16'd0) ? 16'd1 : epoch_inc;
        result.given_epoch = epoch_src_nxt;
      end
      lota_pkg::ACT_CLAIM: begin
        if (lota_pkg::is_transport(item.who) && owner_kind_r == lota_pkg::KIND_NONE &&
            owner_sess_r == 16'd0) begin
          owner_kind_nxt = item.who;
          owner_sess_nxt = item.epoch;
          base_nxt       = now_r;
          result.ok      = 1'b1;
        end
      end
      lota_pkg::ACT_RELEASE: begin
        if (lota_pkg::is_transport(item.who) && owner_kind_r == item.who &&
            owner_sess_r == item.epoch) begin
          owner_kind_nxt = lota_pkg::KIND_NONE;
          owner_sess_nxt = 16'd0;
        end
      end
      lota_pkg::ACT_TERMINAL: begin
        result.prev_who   = owner_kind_r;
        result.prev_epoch = owner_sess_r;
        owner_kind_nxt    = lota_pkg::KIND_TERMINAL;
        owner_sess_nxt    = 16'd0;
      end
      lota_pkg::ACT_STAMP: begin
        base_nxt = now_r;
      end
      default: begin
      end
    endcase
    result.owner_who   = owner_kind_nxt;
    result.owner_epoch = owner_sess_nxt;
    result.is_owner    = (item.who != lota_pkg::KIND_NONE) && (item.who == owner_kind_nxt) &&
                         (item.epoch == owner_sess_nxt);
    result.idle_ms     = lota_pkg::is_transport(owner_kind_nxt) ? (now_nxt - base_nxt) : 32'd0;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      owner_kind_r <= lota_pkg::KIND_NONE;
      owner_sess_r <= 16'd0;
      epoch_src_r  <= 16'd0;
      now_r        <= 32'd0;
      base_r       <= 32'd0;
    end else if (step) begin
      owner_kind_r <= owner_kind_nxt;
      owner_sess_r <= owner_sess_nxt;
      epoch_src_r  <= epoch_src_nxt;
      now_r        <= now_nxt;
      base_r       <= base_nxt;
    end
  end

  a_unowned_clear: assert property (@(posedge clk) disable iff (!rst_n)
    owner_kind_r == lota_pkg::KIND_NONE |-> owner_sess_r == 16'd0)
    else $error("unowned slot holds an epoch");

  a_epoch_nonzero: assert property (@(posedge clk) disable iff (!rst_n)
    step && item.action == lota_pkg::ACT_EPOCH |=> epoch_src_r != 16'd0)
    else $error("epoch allocator produced zero");

  a_tick_advance: assert property (@(posedge clk) disable iff (!rst_n)
    step && item.action == lota_pkg::ACT_TICK |=> now_r == $past(now_r) + 32'd1)
    else $error("tick did not advance time");

  a_idle_gated: assert property (@(posedge clk) disable iff (!rst_n)
    !lota_pkg::is_transport(result.owner_who) |-> result.idle_ms == 32'd0)
    else $error("idle count without a transport owner");

endmodule
`default_nettype wire

@@ rtl/link_ownership_token_arbiter.sv @@
`default_nettype none
// link ownership token arbiter
// input channel: in_valid / in_stall / in_data, one action per transfer
// (tick, new epoch, claim, release, mark terminal, stamp activity, query)
// output channel: out_valid / out_stall / out_data, exactly one result per
// action, in order, carrying the owner after the action, the is-owner flag
// and the idle milliseconds since the last activity baseline
// path: a taken action goes into the input register, then through the update
// and into the result register, which drives the output channel
// throughput: one action per cycle while out_stall is low; the whole step is
// a single compare and update pass over owner slot, epoch and ms counters
// stall: out_stall holds the output register; an empty input register still
// takes one transfer, and in_stall rises in the same cycle once a held item
// meets a stalled result
// reset: synchronous active-low rst_n clears the slot to unowned and zeroes
// the epoch counter, the ms counter, the baseline and both valid flags
module link_ownership_token_arbiter (
  input  wire logic                clk,
  input  wire logic                rst_n,
  input  wire logic                in_valid,
  output logic                     in_stall,
  input  wire lota_pkg::in_item_t  in_data,
  output logic                     out_valid,
  input  wire logic                out_stall,
  output lota_pkg::out_item_t      out_data
);

  logic                 in_vld_r;
  lota_pkg::in_item_t   in_item_r;
  logic                 out_vld_r;
  lota_pkg::out_item_t  out_item_r;
  lota_pkg::out_item_t  result;
  logic                 advance;

  // a held item moves on when the output register is free or being emptied
  assign advance  = in_vld_r && (!out_vld_r || !out_stall);
  assign in_stall = in_vld_r && !advance;

  lota_core u_core (
    .clk    (clk),
    .rst_n  (rst_n),
    .step   (advance),
    .item   (in_item_r),
    .result (result)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_vld_r  <= 1'b0;
      out_vld_r <= 1'b0;
    end else begin
      if (!in_stall) begin
        in_vld_r <= in_valid;
      end
      if (advance) begin
        out_vld_r <= 1'b1;
      end else if (!out_stall) begin
        out_vld_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && !in_stall) begin
      in_item_r <= in_data;
    end
    if (advance) begin
      out_item_r <= result;
    end
  end

  assign out_valid = out_vld_r;
  assign out_data  = out_item_r;

  a_no_overwrite: assert property (@(posedge clk) disable iff (!rst_n)
    out_vld_r && out_stall |-> !advance)
    else $error("stalled result overwritten");

  a_hold_input: assert property (@(posedge clk) disable iff (!rst_n)
    in_stall |=> in_vld_r && $stable(in_item_r))
    else $error("held item lost while stalled");

  a_result_follows: assert property (@(posedge clk) disable iff (!rst_n)
    advance |=> out_vld_r)
    else $error("processed item did not reach the output");

endmodule
`default_nettype wire

@@ dv/owner_slot_checker.sv @@
module owner_slot_checker (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                in_valid,
  input  logic                in_stall,
  input  lota_pkg::in_item_t  in_data,
  input  logic                out_valid,
  input  logic                out_stall,
  input  lota_pkg::out_item_t out_data,
  output int                  fail_count,
  output int                  pending,
  output int                  checked
);
  import lota_pkg::*;

  logic [1:0]  slot_who;
  logic [15:0] slot_epoch;
  logic [15:0] epoch_ctr;
  logic [31:0] ms_now;
  logic [31:0] ms_base;

  out_item_t owner_reports_q[$];

  function automatic logic transport_kind(input logic [1:0] k);
    return (k == KIND_BLE) || (k == KIND_LAN);
  endfunction

  // one atomic action on the shadow slot, returns the report it should produce
  task automatic apply_action(input in_item_t act, output out_item_t rep);
    rep = '0;
    case (act.action)
      ACT_TICK: begin
        ms_now = ms_now + 32'd1;
      end
      ACT_EPOCH: begin
        epoch_ctr = epoch_ctr + 16'd1;
        // zero is never handed out
        if (epoch_ctr == 16'd0) epoch_ctr = 16'd1;
        rep.given_epoch = epoch_ctr;
      end
      ACT_CLAIM: begin
        if (transport_kind(act.who) && slot_who == KIND_NONE && slot_epoch == 16'd0) begin
          slot_who   = act.who;
          slot_epoch = act.epoch;
          ms_base    = ms_now;
          rep.ok     = 1'b1;
        end
      end
      ACT_RELEASE: begin
        if (transport_kind(act.who) && slot_who == act.who && slot_epoch == act.epoch) begin
          slot_who   = KIND_NONE;
          slot_epoch = 16'd0;
        end
      end
      ACT_TERMINAL: begin
        rep.prev_who   = slot_who;
        rep.prev_epoch = slot_epoch;
        slot_who       = KIND_TERMINAL;
        slot_epoch     = 16'd0;
      end
      ACT_STAMP: begin
        ms_base = ms_now;
      end
      default: ;
    endcase
    rep.owner_who   = slot_who;
    rep.owner_epoch = slot_epoch;
    rep.is_owner    = (act.who != KIND_NONE) && (act.who == slot_who) &&
                      (act.epoch == slot_epoch);
    rep.idle_ms     = transport_kind(slot_who) ? (ms_now - ms_base) : 32'd0;
  endtask

  task automatic check_field(input string name, input logic [31:0] want,
                             input logic [31:0] got);
    if (want !== got) begin
      $error("%s: expected 0x%0h, got 0x%0h", name, want, got);
      fail_count++;
    end
  endtask

  initial begin
    fail_count = 0;
    pending    = 0;
    checked    = 0;
  end

  always @(posedge clk) begin
    out_item_t rep;
    out_item_t want;
    if (!rst_n) begin
      slot_who   = KIND_NONE;
      slot_epoch = 16'd0;
      epoch_ctr  = 16'd0;
      ms_now     = 32'd0;
      ms_base    = 32'd0;
      owner_reports_q.delete();
    end else begin
      if (in_valid && !in_stall) begin
        apply_action(in_data, rep);
        owner_reports_q.push_back(rep);
      end
      if (out_valid && !out_stall) begin
        if (owner_reports_q.size() == 0) begin
          $error("result transfer with no action outstanding");
          fail_count++;
        end else begin
          want = owner_reports_q.pop_front();
          check_field("ok",          32'(want.ok),          32'(out_data.ok));
          check_field("given_epoch", 32'(want.given_epoch), 32'(out_data.given_epoch));
          check_field("prev_who",    32'(want.prev_who),    32'(out_data.prev_who));
          check_field("prev_epoch",  32'(want.prev_epoch),  32'(out_data.prev_epoch));
          check_field("owner_who",   32'(want.owner_who),   32'(out_data.owner_who));
          check_field("owner_epoch", 32'(want.owner_epoch), 32'(out_data.owner_epoch));
          check_field("is_owner",    32'(want.is_owner),    32'(out_data.is_owner));
          check_field("idle_ms",     want.idle_ms,          out_data.idle_ms);
          checked++;
        end
      end
    end
    pending = owner_reports_q.size();
  end

endmodule

@@ dv/tb.sv @@
module tb;
  import lota_pkg::*;

  localparam logic [2:0] ACT_UNUSED = 3'd7;

  logic      clk;
  logic      rst_n;
  logic      in_valid;
  logic      in_stall;
  in_item_t  in_data;
  logic      out_valid;
  logic      out_stall;
  out_item_t out_data;

  int fail_count;
  int pending;
  int checked;

  int sent;
  int src_idle;
  int snk_stall;

  link_ownership_token_arbiter dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_data  (out_data)
  );

  owner_slot_checker chk (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_valid   (in_valid),
    .in_stall   (in_stall),
    .in_data    (in_data),
    .out_valid  (out_valid),
    .out_stall  (out_stall),
    .out_data   (out_data),
    .fail_count (fail_count),
    .pending    (pending),
    .checked    (checked)
  );

  initial begin
    clk = 1'b0;
    forever #6 clk = ~clk;
  end

  initial begin
    #30000000;
    $display("[link_ownership_token_arbiter] ERROR");
    $finish;
  end

  // receiver side stall pattern
  initial begin
    out_stall = 1'b0;
    forever begin
      @(negedge clk);
      out_stall <= ($urandom_range(99) < snk_stall);
    end
  end

  // called just after a falling edge, returns just after a falling edge
  task automatic send_action(input in_item_t act);
    while ($urandom_range(99) < src_idle) begin
      in_valid <= 1'b0;
      @(negedge clk);
    end
    in_valid <= 1'b1;
    in_data  <= act;
    do @(posedge clk); while (in_stall);
    @(negedge clk);
    sent++;
  endtask

  function automatic logic [15:0] pick_epoch();
    case ($urandom_range(3))
      0:       return 16'h0000;
      1:       return 16'hFFFF;
      default: return 16'($urandom);
    endcase
  endfunction

  function automatic in_item_t noise_item(input bit allow_terminal);
    in_item_t it;
    it.action = 3'($urandom_range(7));
    if (!allow_terminal && it.action == ACT_TERMINAL) it.action = ACT_QUERY;
    it.who   = 2'($urandom_range(3));
    it.epoch = pick_epoch();
    return it;
  endfunction

  // claim, some mixed activity, then a release (mostly exact)
  task automatic run_session();
    in_item_t   it;
    logic [1:0] w;
    logic [15:0] e;
    int n;
    w = ($urandom_range(9) == 0) ? 2'($urandom_range(3)) : 2'($urandom_range(1, 2));
    e = pick_epoch();
    send_action('{ACT_CLAIM, w, e});
    n = $urandom_range(1, 8);
    repeat (n) begin
      case ($urandom_range(5))
        0, 1:    it = '{ACT_TICK, 2'($urandom), 16'($urandom)};
        2:       it = '{ACT_STAMP, 2'($urandom), 16'($urandom)};
        3:       it = '{ACT_QUERY, w, e};
        4:       it = '{ACT_EPOCH, 2'($urandom), 16'($urandom)};
        default: it = noise_item(1'b0);
      endcase
      send_action(it);
    end
    case ($urandom_range(9))
      0:       it = '{ACT_RELEASE, w, e ^ (16'h1 << $urandom_range(15))};
      1:       it = '{ACT_RELEASE, w ^ 2'($urandom_range(1, 3)), e};
      default: it = '{ACT_RELEASE, w, e};
    endcase
    send_action(it);
  endtask

  initial begin
    int idle_tab[4];
    int stall_tab[4];
    int goal;
    idle_tab  = '{0, 63, 0, 8};
    stall_tab = '{0, 0, 63, 8};
    rst_n     = 1'b0;
    in_valid  = 1'b0;
    in_data   = '0;
    sent      = 0;
    src_idle  = 0;
    snk_stall = 0;
    repeat (2) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    // directed: claims, releases, idle counting, who none and the unused code
    send_action('{ACT_QUERY,   KIND_NONE, 16'h0000});
    send_action('{ACT_TICK,    KIND_NONE, 16'h0000});
    send_action('{ACT_EPOCH,   KIND_NONE, 16'h0000});
    send_action('{ACT_EPOCH,   KIND_LAN,  16'hFFFF});
    send_action('{ACT_CLAIM,   KIND_NONE, 16'h0005});
    send_action('{ACT_CLAIM,   KIND_TERMINAL, 16'h0005});
    send_action('{ACT_CLAIM,   KIND_BLE,  16'hFFFF});
    send_action('{ACT_QUERY,   KIND_BLE,  16'hFFFF});
    send_action('{ACT_TICK,    KIND_BLE,  16'hFFFF});
    send_action('{ACT_TICK,    KIND_NONE, 16'h0000});
    send_action('{ACT_CLAIM,   KIND_LAN,  16'h0001});
    send_action('{ACT_RELEASE, KIND_BLE,  16'hFFFE});
    send_action('{ACT_RELEASE, KIND_LAN,  16'hFFFF});
    send_action('{ACT_STAMP,   KIND_NONE, 16'h0000});
    send_action('{ACT_TICK,    KIND_NONE, 16'h0000});
    send_action('{ACT_RELEASE, KIND_BLE,  16'hFFFF});
    send_action('{ACT_QUERY,   KIND_NONE, 16'h0000});
    send_action('{ACT_CLAIM,   KIND_LAN,  16'h0000});
    send_action('{ACT_QUERY,   KIND_LAN,  16'h0000});
    send_action('{ACT_UNUSED,  KIND_LAN,  16'h0000});
    send_action('{ACT_RELEASE, KIND_LAN,  16'h0000});
    send_action('{ACT_STAMP,   KIND_BLE,  16'hA5A5});

    for (int p = 0; p < 4; p++) begin
      src_idle  = idle_tab[p];
      snk_stall = stall_tab[p];
      goal      = sent + 450;
      while (sent < goal) begin
        if ($urandom_range(4) == 0) send_action(noise_item(1'b0));
        else run_session();
      end
    end

    // terminal takeover sticks until reset, so it comes last
    send_action('{ACT_TERMINAL, KIND_BLE,      16'h1234});
    send_action('{ACT_QUERY,    KIND_TERMINAL, 16'h0000});
    send_action('{ACT_CLAIM,    KIND_BLE,      16'h0007});
    send_action('{ACT_RELEASE,  KIND_TERMINAL, 16'h0000});
    send_action('{ACT_TERMINAL, KIND_NONE,     16'h0000});
    send_action('{ACT_TICK,     KIND_NONE,     16'h0000});
    send_action('{ACT_QUERY,    KIND_TERMINAL, 16'h0000});
    repeat (80) send_action(noise_item(1'b1));

    in_valid <= 1'b0;
    while (pending != 0) @(posedge clk);
    repeat (8) @(posedge clk);

    $display("run covered %0d actions with %0d results checked: directed cases,",
             sent, checked);
    $display("claim/release sessions under four idle and stall mixes, and terminal takeover");
    if (fail_count == 0 && pending == 0) begin
      $display("[link_ownership_token_arbiter] OK");
    end else begin
      $display("[link_ownership_token_arbiter] ERROR");
    end
    $finish;
  end

endmodule

@@ link_ownership_token_arbiter.f @@
rtl/lota_pkg.sv
rtl/lota_core.sv
rtl/link_ownership_token_arbiter.sv
dv/owner_slot_checker.sv
dv/tb.sv
